### hw/rtl/tnos_pkg.sv
// Shared types and constants of the timed note-off scheduler.
// Used by tnos_table and timed_note_off_scheduler; depends on nothing.

package tnos_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int MAX_RESULTS   = 64;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_RESULTS + 1);

	localparam logic [1:0] KIND_ACCEPTED = 2'd0;
	localparam logic [1:0] KIND_DROPPED  = 2'd1;
	localparam logic [1:0] KIND_NOTE_OFF = 2'd2;

	localparam logic CMD_SCHEDULE = 1'b0;
	localparam logic CMD_TICK     = 1'b1;

	typedef struct packed {
		logic [31:0] due;
		logic [6:0]  note;
		logic [4:0]  chan;
	} entry_t;

	typedef struct packed {
		logic             rd_en;
		logic             wr_en;    // also marks the entry active
		logic             clr_act;
		logic [IDX_W-1:0] addr;
	} tbl_req_t;

endpackage

### hw/rtl/tnos_table.sv
// Event table: entry memory with registered read plus per-entry active flags.
// Depends on tnos_pkg.

module tnos_table
	import tnos_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  tbl_req_t req,
	input  entry_t   wr_data,
	output entry_t   rd_data,
	output logic     act_bit
);

	entry_t                   mem [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] active_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.addr] <= wr_data;
		end
		// hold read data until the next read so a stalled check still sees it
		if (req.rd_en) begin
			rd_data <= mem[req.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
		end else if (req.wr_en) begin
			active_q[req.addr] <= 1'b1;
		end else if (req.clr_act) begin
			active_q[req.addr] <= 1'b0;
		end
	end

	assign act_bit = active_q[req.addr];

endmodule

### hw/rtl/timed_note_off_scheduler.sv
// Top level of the timed note-off scheduler: command sequencer, result register
// and drop counter around the event table. Depends on tnos_pkg and tnos_table.
//
//   channel   dir  tdata                                   tuser        tlast
//   s_axis    in   now_ms, note_number, midi_channel,      command      -
//                  delay_ms
//   m_axis    out  out_note, out_channel, drops_so_far     kind         last_of_run
//
// A schedule beat walks the active flags one entry a cycle until the first free
// one, writes the entry there and replies; with no free entry it counts a drop.
// A tick beat steps past an inactive entry in ST_SCAN; an active one gets a table
// read in ST_SCAN, then a due check in ST_CHECK, as the table read is registered.
// Each note-off is held in a pending register until the next one, so the final
// one can carry tlast. Reset clears the active flags at once; no clearing pass
// is needed. A stalled m_axis holds the sequencer wherever it has a beat to hand
// over; s_axis is ready only when idle.

module timed_note_off_scheduler
	import tnos_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // now_ms, note_number, midi_channel, delay_ms, pad
	input  logic [0:0]  s_axis_tuser,   // command
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // out_note, out_channel, drops_so_far, pad
	output logic [1:0]  m_axis_tuser,   // kind
	output logic        m_axis_tlast
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_FIND  = 6'b000010,
		ST_REPLY = 6'b000100,
		ST_SCAN  = 6'b001000,
		ST_CHECK = 6'b010000,
		ST_FLUSH = 6'b100000
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] cnt_q;
	logic [31:0]      now_q;
	logic [31:0]      due_q;
	logic [6:0]       note_q;
	logic [4:0]       chan_q;
	logic [1:0]       reply_kind_q;
	logic [31:0]      drops_q;
	logic             pend_v_q;
	logic [6:0]       pend_note_q;
	logic [4:0]       pend_chan_q;

	logic             out_valid_q;
	logic [1:0]       out_kind_q;
	logic [6:0]       out_note_q;
	logic [4:0]       out_chan_q;
	logic [31:0]      out_drops_q;
	logic             out_last_q;

	tbl_req_t         tbl_req;
	entry_t           tbl_wr_data;
	entry_t           tbl_rd_data;
	logic             act_bit;

	logic             in_fire;
	logic             out_free;
	logic             idx_last;
	logic [31:0]      age;
	logic             is_due;
	logic             push;
	logic [1:0]       push_kind;
	logic [6:0]       push_note;
	logic [4:0]       push_chan;
	logic             push_last;

	tnos_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (tbl_req),
		.wr_data (tbl_wr_data),
		.rd_data (tbl_rd_data),
		.act_bit (act_bit)
	);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign idx_last      = (idx_q == IDX_W'(TABLE_ENTRIES - 1));
	assign age           = now_q - tbl_rd_data.due;
	assign is_due        = !age[31];
	assign tbl_wr_data   = '{due: due_q, note: note_q, chan: chan_q};

	// table requests and result pushes
	always_comb begin
		tbl_req      = '0;
		tbl_req.addr = idx_q;
		push         = 1'b0;
		push_kind    = KIND_NOTE_OFF;
		push_note    = pend_note_q;
		push_chan    = pend_chan_q;
		push_last    = 1'b0;
		case (state_q)
			ST_FIND: begin
				tbl_req.wr_en = !act_bit;
			end
			ST_REPLY: begin
				push      = out_free;
				push_kind = reply_kind_q;
				push_note = '0;
				push_chan = '0;
				push_last = 1'b1;
			end
			ST_SCAN: begin
				tbl_req.rd_en = act_bit && (cnt_q != CNT_W'(MAX_RESULTS));
			end
			ST_CHECK: begin
				if (is_due && (!pend_v_q || out_free)) begin
					tbl_req.clr_act = 1'b1;
					push            = pend_v_q;
				end
			end
			ST_FLUSH: begin
				push      = pend_v_q && out_free;
				push_last = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			now_q  <= s_axis_tdata[31:0];
			note_q <= s_axis_tdata[38:32];
			chan_q <= s_axis_tdata[43:39];
			due_q  <= s_axis_tdata[31:0] + {16'd0, s_axis_tdata[59:44]};
		end
		if (state_q == ST_CHECK && tbl_req.clr_act) begin
			pend_note_q <= tbl_rd_data.note;
			pend_chan_q <= tbl_rd_data.chan;
		end
		// capture the drop count with the beat so a later drop cannot alter it
		if (push) begin
			out_kind_q  <= push_kind;
			out_note_q  <= push_note;
			out_chan_q  <= push_chan;
			out_drops_q <= drops_q;
			out_last_q  <= push_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			cnt_q        <= '0;
			drops_q      <= '0;
			pend_v_q     <= 1'b0;
			reply_kind_q <= KIND_ACCEPTED;
			out_valid_q  <= 1'b0;
		end else begin
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						idx_q    <= '0;
						cnt_q    <= '0;
						pend_v_q <= 1'b0;
						state_q  <= (s_axis_tuser[0] == CMD_TICK) ? ST_SCAN : ST_FIND;
					end
				end
				ST_FIND: begin
					if (!act_bit) begin
						reply_kind_q <= KIND_ACCEPTED;
						state_q      <= ST_REPLY;
					end else if (idx_last) begin
						if (drops_q != '1) begin
							drops_q <= drops_q + 32'd1;
						end
						reply_kind_q <= KIND_DROPPED;
						state_q      <= ST_REPLY;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_REPLY: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					if (cnt_q == CNT_W'(MAX_RESULTS)) begin
						state_q <= ST_FLUSH;
					end else if (act_bit) begin
						state_q <= ST_CHECK;
					end else if (idx_last) begin
						state_q <= ST_FLUSH;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_CHECK: begin
					// a due entry waits here while the previous note-off cannot move out
					if (!is_due || tbl_req.clr_act) begin
						if (tbl_req.clr_act) begin
							pend_v_q <= 1'b1;
							cnt_q    <= cnt_q + CNT_W'(1);
						end
						if (idx_last) begin
							state_q <= ST_FLUSH;
						end else begin
							idx_q   <= idx_q + IDX_W'(1);
							state_q <= ST_SCAN;
						end
					end
				end
				ST_FLUSH: begin
					if (!pend_v_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						pend_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {4'd0, out_drops_q, out_chan_q, out_note_q};

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_v_q)
		else $error("held note-off left behind after a tick");

	a_count_capped: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_RESULTS))
		else $error("tick emitted more note-offs than allowed");

	a_write_only_in_find: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_req.wr_en |-> (state_q == ST_FIND))
		else $error("table written outside a schedule search");

	a_drops_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_FIND) |=> (drops_q == $past(drops_q)))
		else $error("drop counter moved outside a schedule search");

endmodule
